>>> rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Fixed-point formats, register indexes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Value width and fraction bits of the Q formats
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Step counter width for the serial divider and multiplier
    localparam int CNT_W = $clog2(FRAC_BITS);

    // 1.0 in unsigned Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS
    localparam logic [DATA_WIDTH-1:0] ONE_FX = DATA_WIDTH'(1) << FRAC_BITS;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PROCESS_NOISE     = 3'd0;
    localparam t_cfg_idx CFG_MEASUREMENT_NOISE = 3'd1;
    localparam t_cfg_idx CFG_START_COVARIANCE  = 3'd2;
    localparam t_cfg_idx CFG_START_ESTIMATE    = 3'd3;
    localparam t_cfg_idx CFG_PRESET_MODE       = 3'd4;

    typedef logic [DATA_WIDTH-1:0] t_value;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PRED = 7'b0000010,
        S_GAIN = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_HOLD = 7'b1000000
    } t_state;

endpackage

>>> rtl/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional Kalman filter, bit-serial datapath
// Predicts the covariance, divides out the gain one bit per cycle, then
// scales the innovation and the covariance by shift-and-add multipliers.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake                         payload
//  ---------   ---  --------------------------------  ------------------------
//  sample      in   i_sample_valid / o_sample_ready   i_sample   (signed Q16.16)
//  estimate    out  o_estimate_valid / i_estimate_ready o_estimate (signed Q16.16)
//  config      in   i_cfg_valid / o_cfg_ready         i_cfg_index, i_cfg_data
//
//  A filter update runs from transfer to result through predict, gain setup,
//  FRAC_BITS divider steps, FRAC_BITS multiplier steps, finish and output
//  load; the next sample is taken once the sequencer is back in idle. A zero
//  gain denominator or zero measurement noise skips the divider. The seeded
//  first sample goes from its transfer straight to the result hold.
//  The rate is set by the one-bit-per-cycle divider and multipliers.
//  Synchronous active-low reset clears the filter state and restores the
//  register defaults; no clearing pass follows. A stalled output holds the
//  finished result in the sequencer until the output register frees.
//
module scalar_kalman_filter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample channel
    input  logic                   i_sample_valid,
    output logic                   o_sample_ready,
    input  skf_pkg::t_value        i_sample,
    // estimate channel
    output logic                   o_estimate_valid,
    input  logic                   i_estimate_ready,
    output skf_pkg::t_value        o_estimate,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  skf_pkg::t_cfg_idx      i_cfg_index,
    input  skf_pkg::t_value        i_cfg_data
);
    import skf_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int FW = FRAC_BITS;

    // Control and filter state
    t_state          r_state,   n_state;
    logic            r_started, n_started;
    logic            r_ovalid,  n_ovalid;
    t_value          r_x,       n_x;
    t_value          r_p,       n_p;

    // Configuration registers
    t_value          r_pnoise,  n_pnoise;
    t_value          r_mnoise,  n_mnoise;
    t_value          r_scov,    n_scov;
    t_value          r_sest,    n_sest;
    logic            r_preset,  n_preset;

    // Datapath registers
    t_value          r_sample,  n_sample;
    logic [DW:0]     r_rem,     n_rem;
    logic [DW:0]     r_den,     n_den;
    logic [FW-1:0]   r_g,       n_g;
    logic [FW-1:0]   r_m,       n_m;
    logic            r_gz,      n_gz;
    logic [DW:0]     r_mag,     n_mag;
    logic            r_neg,     n_neg;
    logic [DW:0]     r_acc_s,   n_acc_s;
    t_value          r_acc_p,   n_acc_p;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    t_value          r_res,     n_res;
    t_value          r_oest,    n_oest;

    // Combinational datapath pieces
    logic [DW:0]     w_psum;
    t_value          w_psat;
    logic [DW:0]     w_den;
    logic [DW+1:0]   w_rem2;
    logic [DW+1:0]   w_sub;
    logic            w_ge;
    logic [FW-1:0]   w_g_div;
    logic [DW:0]     w_diff;
    logic [DW+1:0]   w_sum_s;
    logic [DW:0]     w_sum_p;
    logic [DW+1:0]   w_xe;
    logic [DW+1:0]   w_xnew;
    t_value          w_xsat;
    logic            w_last;

    assign o_sample_ready   = (r_state == S_IDLE);
    assign o_estimate_valid = r_ovalid;
    assign o_estimate       = r_oest;
    assign o_cfg_ready      = 1'b1;

    // Predict: p + q, saturated
    assign w_psum = {1'b0, r_p} + {1'b0, r_pnoise};
    assign w_psat = w_psum[DW] ? {DW{1'b1}} : w_psum[DW-1:0];

    // Gain denominator held exactly
    assign w_den = {1'b0, r_p} + {1'b0, r_mnoise};

    // One restoring division step
    assign w_rem2  = {r_rem, 1'b0};
    assign w_ge    = (w_rem2 >= {1'b0, r_den});
    assign w_sub   = w_rem2 - {1'b0, r_den};
    assign w_g_div = {r_g[FW-2:0], w_ge};

    // Innovation, one bit wider than the samples
    assign w_diff = {r_sample[DW-1], r_sample} - {r_x[DW-1], r_x};

    // One shift-and-add step of each multiplier, LSB of the multiplier first
    assign w_sum_s = {1'b0, r_acc_s} + (r_g[0] ? {1'b0, r_mag} : {(DW+2){1'b0}});
    assign w_sum_p = {1'b0, r_acc_p} + (r_m[0] ? {1'b0, r_p} : {(DW+1){1'b0}});

    // Apply the step and saturate to the signed range
    assign w_xe   = {{2{r_x[DW-1]}}, r_x};
    assign w_xnew = r_neg ? (w_xe - {1'b0, r_acc_s}) : (w_xe + {1'b0, r_acc_s});
    always_comb begin
        if (w_xnew[DW+1:DW-1] == 3'b000 || w_xnew[DW+1:DW-1] == 3'b111) begin
            w_xsat = w_xnew[DW-1:0];
        end else if (w_xnew[DW+1]) begin
            w_xsat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_xsat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    assign w_last = (r_cnt == CNT_W'(FW - 1));

    // Next-state logic
    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_ovalid  = r_ovalid;
        n_x       = r_x;
        n_p       = r_p;
        n_pnoise  = r_pnoise;
        n_mnoise  = r_mnoise;
        n_scov    = r_scov;
        n_sest    = r_sest;
        n_preset  = r_preset;
        n_sample  = r_sample;
        n_rem     = r_rem;
        n_den     = r_den;
        n_g       = r_g;
        n_m       = r_m;
        n_gz      = r_gz;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_acc_s   = r_acc_s;
        n_acc_p   = r_acc_p;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_oest    = r_oest;

        // Register writes; unknown indexes drop
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE:     n_pnoise = i_cfg_data;
                CFG_MEASUREMENT_NOISE: n_mnoise = i_cfg_data;
                CFG_START_COVARIANCE:  n_scov   = i_cfg_data;
                CFG_START_ESTIMATE:    n_sest   = i_cfg_data;
                CFG_PRESET_MODE:       n_preset = i_cfg_data[0];
                default: ;
            endcase
        end

        // Release the output register on transfer
        if (r_ovalid && i_estimate_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_sample_valid) begin
                    n_sample = i_sample;
                    if (!r_started) begin
                        n_started = 1'b1;
                        if (!r_preset) begin
                            // Seeded start: take the sample as is
                            n_x     = i_sample;
                            n_p     = ONE_FX;
                            n_res   = i_sample;
                            n_state = S_HOLD;
                        end else begin
                            n_x     = r_sest;
                            n_p     = r_scov;
                            n_state = S_PRED;
                        end
                    end else begin
                        n_state = S_PRED;
                    end
                end
            end
            S_PRED: begin
                n_p     = w_psat;
                n_state = S_GAIN;
            end
            S_GAIN: begin
                n_neg   = w_diff[DW];
                n_mag   = w_diff[DW] ? (~w_diff + 1'b1) : w_diff;
                n_acc_s = '0;
                n_acc_p = '0;
                n_cnt   = '0;
                priority if (w_den == '0) begin
                    // Zero denominator: no gain
                    n_g     = '0;
                    n_m     = '0;
                    n_gz    = 1'b1;
                    n_state = S_MUL;
                end else if (r_mnoise == '0) begin
                    // No measurement noise: gain just below one
                    n_g     = {FW{1'b1}};
                    n_m     = FW'(1);
                    n_gz    = 1'b0;
                    n_state = S_MUL;
                end else begin
                    n_rem   = {1'b0, r_p};
                    n_den   = w_den;
                    n_g     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_sub[DW:0] : w_rem2[DW:0];
                n_g   = w_g_div;
                n_cnt = r_cnt + 1'b1;
                if (w_last) begin
                    n_m     = ~w_g_div + 1'b1;
                    n_gz    = (w_g_div == '0);
                    n_acc_s = '0;
                    n_acc_p = '0;
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc_s = w_sum_s[DW+1:1];
                n_acc_p = w_sum_p[DW:1];
                n_g     = r_g >> 1;
                n_m     = r_m >> 1;
                n_cnt   = r_cnt + 1'b1;
                if (w_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_x     = w_xsat;
                n_p     = r_gz ? r_p : r_acc_p;
                n_res   = w_xsat;
                n_state = S_HOLD;
            end
            S_HOLD: begin
                // Wait for a free output register
                if (!r_ovalid || i_estimate_ready) begin
                    n_ovalid = 1'b1;
                    n_oest   = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control, filter state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
            r_x       <= '0;
            r_p       <= '0;
            r_pnoise  <= '0;
            r_mnoise  <= ONE_FX;
            r_scov    <= ONE_FX;
            r_sest    <= '0;
            r_preset  <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_ovalid  <= n_ovalid;
            r_x       <= n_x;
            r_p       <= n_p;
            r_pnoise  <= n_pnoise;
            r_mnoise  <= n_mnoise;
            r_scov    <= n_scov;
            r_sest    <= n_sest;
            r_preset  <= n_preset;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_g      <= n_g;
        r_m      <= n_m;
        r_gz     <= n_gz;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_acc_s  <= n_acc_s;
        r_acc_p  <= n_acc_p;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        r_oest   <= n_oest;
    end

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && o_sample_ready) |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after a sample transfer");

    a_fin_to_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_HOLD))
        else $error("finish step did not move to result hold");

    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped without reset");

    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_gz) |-> (r_acc_p <= r_p))
        else $error("updated covariance exceeds predicted covariance");

    a_load_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_HOLD))
        else $error("output register loaded outside result hold");

endmodule

>>> bench/skf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skf_checker: estimate predictor and scoreboard for scalar_kalman_filter
// Watches the sample, estimate and configuration channels. Every accepted
// sample is run through a local copy of the filter, and the expected
// estimate is queued. Every accepted estimate is compared with the oldest
// queued one. Hands the mismatch count and the number of estimates still
// owed to the testbench top.
// ----------------------------------------------------------------------------
module skf_checker
    import skf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_sample_valid,
    input  logic       o_sample_ready,
    input  t_value     i_sample,
    input  logic       o_estimate_valid,
    input  logic       i_estimate_ready,
    input  t_value     o_estimate,
    input  logic       i_cfg_valid,
    input  logic       o_cfg_ready,
    input  t_cfg_idx   i_cfg_index,
    input  t_value     i_cfg_data,
    output int         o_mismatches,
    output int         o_outstanding
);

    localparam int          W     = DATA_WIDTH;
    localparam int          F     = FRAC_BITS;
    localparam logic [63:0] VMAX  = (64'd1 << W) - 64'd1;
    localparam logic [63:0] UNITY = 64'd1 << F;
    localparam longint      SMAX  = longint'(VMAX >> 1);
    localparam longint      SMIN  = -SMAX - 1;

    // Filter registers as the block should hold them
    t_value   proc_noise;
    t_value   meas_noise;
    t_value   init_cov;
    t_value   init_est;
    logic     preset_on;

    // Filter state
    t_value   est_now;
    t_value   cov_now;
    logic     running;

    t_value   owed_estimates[$];
    int       mism_cnt;
    t_value   want;

    // Fixed-point multiply by a Q0.F factor, floor
    function automatic logic [63:0] scale_frac(logic [63:0] a, logic [63:0] m);
        return (a * m) >> F;
    endfunction

    // Gain p / (p + r) in Q0.F, floor, held below one
    function automatic logic [63:0] kalman_gain(logic [63:0] p, logic [63:0] r);
        logic [63:0] d;
        d = p + r;
        if (d == 64'd0) return 64'd0;
        if (r == 64'd0) return UNITY - 64'd1;
        return (p << F) / d;
    endfunction

    // Run one sample through the filter and return the estimate it yields
    function automatic t_value filter_step(t_value sample);
        longint      meas;
        longint      x;
        longint      diff;
        longint      x_new;
        logic [63:0] p;
        logic [63:0] g;
        logic [63:0] mag;
        logic [63:0] step;

        meas = longint'($signed(sample));
        if (!running) begin
            running = 1'b1;
            // seeded start: take the sample as it is
            if (!preset_on) begin
                est_now = sample;
                cov_now = (UNITY > VMAX) ? VMAX[W-1:0] : UNITY[W-1:0];
                return sample;
            end
            est_now = init_est;
            cov_now = init_cov;
        end

        // predict, saturating at the unsigned maximum
        p = 64'(cov_now) + 64'(proc_noise);
        if (p > VMAX) p = VMAX;

        g = kalman_gain(p, 64'(meas_noise));

        // move toward the sample, step truncated toward zero
        x     = longint'($signed(est_now));
        diff  = meas - x;
        mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
        step  = scale_frac(mag, g);
        x_new = (diff < 0) ? x - longint'(step) : x + longint'(step);
        if (x_new > SMAX) x_new = SMAX;
        if (x_new < SMIN) x_new = SMIN;
        est_now = x_new[W-1:0];

        // shrink the covariance by (1 - g)
        cov_now = W'(scale_frac(p, UNITY - g));
        return est_now;
    endfunction

    // Track register writes, predict on sample transfers, compare estimates
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            proc_noise = '0;
            meas_noise = UNITY[W-1:0];
            init_cov   = UNITY[W-1:0];
            init_est   = '0;
            preset_on  = 1'b1;
            est_now    = '0;
            cov_now    = '0;
            running    = 1'b0;
            mism_cnt   = 0;
            owed_estimates.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE:     proc_noise = i_cfg_data;
                    CFG_MEASUREMENT_NOISE: meas_noise = i_cfg_data;
                    CFG_START_COVARIANCE:  init_cov   = i_cfg_data;
                    CFG_START_ESTIMATE:    init_est   = i_cfg_data;
                    CFG_PRESET_MODE:       preset_on  = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (o_estimate_valid && i_estimate_ready) begin
                if (owed_estimates.size() == 0) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("skf_checker: unexpected estimate %h at %0t",
                                 o_estimate, $realtime);
                end else begin
                    want = owed_estimates.pop_front();
                    if (o_estimate !== want) begin
                        mism_cnt++;
                        if (mism_cnt <= 10)
                            $display("skf_checker: estimate expected %h got %h at %0t",
                                     want, o_estimate, $realtime);
                    end
                end
            end

            if (i_sample_valid && o_sample_ready)
                owed_estimates.push_back(filter_step(i_sample));
        end
        o_mismatches  <= mism_cnt;
        o_outstanding <= owed_estimates.size();
    end

endmodule

>>> bench/scalar_kalman_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_tb: stimulus and verdict for scalar_kalman_filter
// Programs the filter registers between bursts of samples, starting with
// directed bursts on range extremes, covariance overflow, unit and zero
// gain, then random bursts around a drifting level with random noise
// settings. Both channel ends idle at random; skf_checker does the checking.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_tb;
    import skf_pkg::*;

    localparam int SETTLE_CYCLES = 45;
    localparam int RANDOM_ITEMS  = 650;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_sample_valid   = 1'b0;
    logic       o_sample_ready;
    t_value     i_sample         = '0;
    logic       o_estimate_valid;
    logic       i_estimate_ready = 1'b0;
    t_value     o_estimate;
    logic       i_cfg_valid      = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index      = CFG_PROCESS_NOISE;
    t_value     i_cfg_data       = '0;

    int         mismatches;
    int         outstanding;

    bit         tx_gaps   = 1'b1;
    bit         rx_stalls = 1'b1;
    int         rx_hold   = 0;
    int         sent      = 0;

    scalar_kalman_filter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_valid   (i_sample_valid),
        .o_sample_ready   (o_sample_ready),
        .i_sample         (i_sample),
        .o_estimate_valid (o_estimate_valid),
        .i_estimate_ready (i_estimate_ready),
        .o_estimate       (o_estimate),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    skf_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_valid   (i_sample_valid),
        .o_sample_ready   (o_sample_ready),
        .i_sample         (i_sample),
        .o_estimate_valid (o_estimate_valid),
        .i_estimate_ready (i_estimate_ready),
        .o_estimate       (o_estimate),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // Estimate sink: after each transfer, stall for a random count
    always @(posedge i_clk) begin
        if (o_estimate_valid && i_estimate_ready)
            rx_hold = rx_stalls ? $urandom_range(0, 17) : 0;
        if (rx_hold > 0) begin
            i_estimate_ready <= 1'b0;
            rx_hold--;
        end else begin
            i_estimate_ready <= 1'b1;
        end
    end

    // Hard stop if the run hangs
    initial begin
        #10_000_000;
        $display("scalar_kalman_filter_tb: FAIL");
        $finish;
    end

    // Transfer one register write after a random gap; valid stays up for a back-to-back write
    task automatic config_write(t_cfg_idx idx, t_value val);
        int gap;
        gap = $urandom_range(0, 17);
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Transfer one sample, after a random gap when gaps are on
    task automatic sample_send(t_value val);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= val;
        do @(posedge i_clk); while (!o_sample_ready);
        sent++;
    endtask

    // Drop valid, let the owed count catch up with the last transfer,
    // wait for every owed estimate, then let the block settle
    task automatic drain();
        i_sample_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_value pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Noise covariance: zero, maximum, anything, up to 2.0 or tiny
    function automatic t_value pick_noise();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return $urandom_range(0, 32'h0002_0000);
            default: return $urandom_range(0, 32'h0000_4000);
        endcase
    endfunction

    initial begin
        t_value center;
        t_value delta;
        int     burst;
        int     kind;
        int     sh;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Start values, random start mode, writes to unused indexes
        config_write(CFG_START_ESTIMATE, $urandom);
        config_write(CFG_START_COVARIANCE, $urandom);
        config_write(CFG_PRESET_MODE, $urandom);
        config_write(CFG_PROCESS_NOISE, 32'h0000_0100);
        config_write(CFG_MEASUREMENT_NOISE, 32'h0001_0000);
        for (int k = int'(CFG_PRESET_MODE) + 1; k < 2 ** CFG_IDX_W; k++)
            config_write(t_cfg_idx'(k), $urandom);
        i_cfg_valid <= 1'b0;
        sample_send('0);
        sample_send(32'h7FFF_FFFF);
        sample_send(32'h8000_0000);
        sample_send(32'h7FFF_FFFF);
        sample_send('1);
        sample_send(32'h0000_0001);
        sample_send(32'h0001_0000);
        sample_send(32'hFFFF_0000);
        drain();

        // Maximum noise: covariance overflow on predict
        config_write(CFG_PROCESS_NOISE, '1);
        config_write(CFG_MEASUREMENT_NOISE, '1);
        i_cfg_valid <= 1'b0;
        sample_send(32'h7FFF_FFFF);
        sample_send(32'h8000_0000);
        sample_send('0);
        drain();

        // No noise: gain just below one, covariance decays to a zero denominator
        config_write(CFG_PROCESS_NOISE, '0);
        config_write(CFG_MEASUREMENT_NOISE, '0);
        i_cfg_valid <= 1'b0;
        sample_send(32'h1234_5678);
        sample_send(32'h8000_0000);
        sample_send(32'h7FFF_FFFF);
        sample_send('0);
        sample_send(32'h5555_5555);
        sample_send(32'hAAAA_AAAA);
        drain();

        // Huge measurement noise: gain near zero
        config_write(CFG_MEASUREMENT_NOISE, '1);
        i_cfg_valid <= 1'b0;
        sample_send(32'h8000_0000);
        sample_send(32'h7FFF_FFFF);
        sample_send(32'h0000_8000);
        drain();

        // Random bursts around a drifting level
        center = $urandom;
        sent   = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_gaps   = ($urandom_range(0, 2) != 0);
            rx_stalls = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0) center = $urandom;

            config_write(CFG_PROCESS_NOISE, pick_noise());
            config_write(CFG_MEASUREMENT_NOISE, pick_noise());
            if ($urandom_range(0, 3) == 0) config_write(CFG_START_COVARIANCE, $urandom);
            if ($urandom_range(0, 3) == 0) config_write(CFG_START_ESTIMATE, $urandom);
            if ($urandom_range(0, 3) == 0) config_write(CFG_PRESET_MODE, $urandom);
            if ($urandom_range(0, 5) == 0)
                config_write(t_cfg_idx'($urandom_range(int'(CFG_PRESET_MODE) + 1,
                                                       2 ** CFG_IDX_W - 1)), $urandom);
            i_cfg_valid <= 1'b0;

            burst = $urandom_range(10, 50);
            repeat (burst) begin
                kind = $urandom_range(0, 15);
                if (kind == 0) begin
                    sample_send($urandom);
                end else if (kind == 1) begin
                    sample_send(pick_extreme());
                end else begin
                    sh    = $urandom_range(0, 20);
                    delta = $urandom_range(0, 1 << sh);
                    if ($urandom_range(0, 1) != 0)
                        sample_send(center - delta);
                    else
                        sample_send(center + delta);
                    if ($urandom_range(0, 7) == 0) center = center + (delta >> 2);
                end
            end
            drain();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("scalar_kalman_filter_tb: PASS");
        end else begin
            $display("scalar_kalman_filter_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/skf_pkg.sv
rtl/scalar_kalman_filter.sv
bench/skf_checker.sv
bench/scalar_kalman_filter_tb.sv
